### rtl/bilinear_image_upscaler_core_assert.svh
// Assertion macros shared by the bilinear upscaler RTL.
`ifndef BILINEAR_IMAGE_UPSCALER_CORE_ASSERT_SVH
`define BILINEAR_IMAGE_UPSCALER_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define BUI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled in reset.
`define BUI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bui_pkg.sv
// Shared types and constants of the bilinear image upscaler.
`default_nettype none
package bui_pkg;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_PRODUCE = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  localparam logic [8:0]  SRC_WIDTH_RST  = 9'd256;
  localparam logic [8:0]  SRC_HEIGHT_RST = 9'd256;
  localparam logic [12:0] DST_WIDTH_RST  = 13'd512;
  localparam logic [12:0] DST_HEIGHT_RST = 13'd512;

  typedef struct packed {
    logic        func;
    logic [7:0]  src_col;
    logic [7:0]  src_row;
    logic [11:0] dst_col;
    logic [11:0] dst_row;
    logic [7:0]  in_blue;
    logic [7:0]  in_green;
    logic [7:0]  in_red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic rem_ok;
  } back_status_t;

  function automatic logic [7:0] pix_chan(input pixel_t p, input int ch);
    logic [23:0] v;
    v = p;
    return v[ch*8 +: 8];
  endfunction

endpackage
`default_nettype wire

### rtl/bilinear_image_upscaler_core.sv
// Top level of the bilinear image upscaler.
// The core keeps a BGR source image in a frame store of MAX_SRC_WIDTH*MAX_SRC_HEIGHT
// entries, written by load items and read by produce items, which return one
// interpolated pixel each. It takes one item per clock when the input queue is not
// full and the output is not stalled: four copies of the frame store give the four
// neighbour reads of a produce item in a single cycle, and the coordinate and
// blending divisions are pipelined one quotient bit per stage. After it leaves the
// input queue, an item passes the coordinate dividers, the registered frame store
// read, the products, the sums and the blending divider; a stalled output freezes
// the whole back part. The frame store has no reset and needs no clearing pass; an
// entry must be loaded before a produce item reads it.
`default_nettype none
module bilinear_image_upscaler_core import bui_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_DIM    = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "bilinear_image_upscaler_core_assert.svh"

  localparam int XW  = $clog2(MAX_SRC_WIDTH);
  localparam int YW  = $clog2(MAX_SRC_HEIGHT);
  localparam int DXW = $clog2(MAX_DST_DIM);
  localparam int AW  = $clog2(MAX_SRC_WIDTH*MAX_SRC_HEIGHT);
  localparam int NXW = DXW + XW;
  localparam int NYW = DXW + YW;
  localparam int EW  = 2 + AW + 24 + NXW + DXW + NYW + DXW + XW + YW;
  localparam int QDEPTH = 4;

  logic            e_prod, e_wok, f_prod, f_wok;
  logic [AW-1:0]   e_waddr, f_waddr;
  pixel_t          e_pix, f_pix;
  logic [NXW-1:0]  e_nx, f_nx;
  logic [NYW-1:0]  e_ny, f_ny;
  logic [DXW-1:0]  e_dx, e_dy, f_dx, f_dy;
  logic [XW-1:0]   e_swm1, f_swm1;
  logic [YW-1:0]   e_shm1, f_shm1;
  logic [EW-1:0]   q_rdata;
  logic            q_full, q_empty, q_pop;
  logic [$clog2(QDEPTH+1)-1:0] q_level;
  back_status_t    bk_status;

  bui_front #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH), .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .MAX_DST_DIM (MAX_DST_DIM)
  ) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_data,
    .is_prod (e_prod), .wr_ok (e_wok), .waddr (e_waddr), .pix (e_pix),
    .nx (e_nx), .dx (e_dx), .ny (e_ny), .dy (e_dy), .swm1 (e_swm1), .shm1 (e_shm1)
  );

  assign in_stall = q_full;

  bui_fifo #(.WIDTH(EW), .DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n,
    .push  (in_valid && !in_stall),
    .wdata ({e_prod, e_wok, e_waddr, e_pix, e_nx, e_dx, e_ny, e_dy, e_swm1, e_shm1}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .level (q_level)
  );

  assign {f_prod, f_wok, f_waddr, f_pix, f_nx, f_dx, f_ny, f_dy, f_swm1, f_shm1} = q_rdata;

  bui_back #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH), .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .MAX_DST_DIM (MAX_DST_DIM)
  ) u_back (
    .clk, .rst_n, .valid_i (!q_empty), .pop (q_pop),
    .is_prod (f_prod), .wr_ok (f_wok), .waddr (f_waddr), .pix (f_pix),
    .nx (f_nx), .dx (f_dx), .ny (f_ny), .dy (f_dy), .swm1 (f_swm1), .shm1 (f_shm1),
    .out_valid, .out_stall, .out_data, .status (bk_status)
  );

  `BUI_ASSERT_NOW(a_rem_below_den, out_valid, bk_status.rem_ok, "blend remainder not below divisor")
  `BUI_ASSERT_NEXT(a_push_fills, in_valid && !in_stall, q_level != '0, "accepted request lost by queue")
  `BUI_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "queue popped while empty")

endmodule
`default_nettype wire

### rtl/bui_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bui_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/bui_div.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
`default_nettype none
module bui_div #(
  parameter int LANES = 1,
  parameter int NW    = 20,
  parameter int DW    = 12,
  parameter int QB    = 8,
  parameter int TW    = 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           valid_i,
  input  wire logic [LANES-1:0][NW-1:0]       num_i,
  input  wire logic [DW-1:0]                  div_i,
  input  wire logic [TW-1:0]                  tag_i,
  output logic                                valid_o,
  output logic      [LANES-1:0][QB-1:0]       quot_o,
  output logic      [LANES-1:0][DW-1:0]       rem_o,
  output logic      [DW-1:0]                  div_o,
  output logic      [TW-1:0]                  tag_o
);

  logic                     v_r [QB];
  logic [LANES-1:0][NW-1:0] rem_r [QB];
  logic [LANES-1:0][QB-1:0] q_r [QB];
  logic [DW-1:0]            d_r [QB];
  logic [TW-1:0]            t_r [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int B = QB - 1 - s;
    logic                     v_in;
    logic [LANES-1:0][NW-1:0] rem_in, rem_nxt;
    logic [LANES-1:0][QB-1:0] q_in, q_nxt;
    logic [DW-1:0]            d_in;
    logic [TW-1:0]            t_in;
    logic [NW-1:0]            dsh;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = num_i;
      assign q_in   = '0;
      assign d_in   = div_i;
      assign t_in   = tag_i;
    end else begin : g_rest
      assign v_in   = v_r[s-1];
      assign rem_in = rem_r[s-1];
      assign q_in   = q_r[s-1];
      assign d_in   = d_r[s-1];
      assign t_in   = t_r[s-1];
    end

    assign dsh = NW'(d_in) << B;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_nxt[l] = rem_in[l] - dsh;
          q_nxt[l]   = q_in[l] | (QB'(1) << B);
        end else begin
          rem_nxt[l] = rem_in[l];
          q_nxt[l]   = q_in[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        q_r[s]   <= q_nxt;
        d_r[s]   <= d_in;
        t_r[s]   <= t_in;
      end
    end
  end

  assign valid_o = v_r[QB-1];
  assign quot_o  = q_r[QB-1];
  assign div_o   = d_r[QB-1];
  assign tag_o   = t_r[QB-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_o[l] = rem_r[QB-1][l][DW-1:0];
    end
  end

endmodule
`default_nettype wire

### rtl/bui_fifo.sv
// Small register queue between the front and back parts.
`default_nettype none
module bui_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  output logic                            full,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [LW-1:0]    level_r, level_nxt;

  assign full  = (level_r == LW'(DEPTH));
  assign empty = (level_r == '0);
  assign level = level_r;
  assign rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    level_nxt = level_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH-1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH-1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      level_nxt = level_r + LW'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      level_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### rtl/bui_front.sv
// Front part: configuration registers, item classification and coordinate products.
`default_nettype none
module bui_front import bui_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_DIM    = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire in_item_t                   in_data,
  output logic                            is_prod,
  output logic                            wr_ok,
  output logic [$clog2(MAX_SRC_WIDTH*MAX_SRC_HEIGHT)-1:0] waddr,
  output pixel_t                          pix,
  output logic [$clog2(MAX_DST_DIM)+$clog2(MAX_SRC_WIDTH)-1:0]  nx,
  output logic [$clog2(MAX_DST_DIM)-1:0]  dx,
  output logic [$clog2(MAX_DST_DIM)+$clog2(MAX_SRC_HEIGHT)-1:0] ny,
  output logic [$clog2(MAX_DST_DIM)-1:0]  dy,
  output logic [$clog2(MAX_SRC_WIDTH)-1:0]  swm1,
  output logic [$clog2(MAX_SRC_HEIGHT)-1:0] shm1
);

  localparam int XW  = $clog2(MAX_SRC_WIDTH);
  localparam int YW  = $clog2(MAX_SRC_HEIGHT);
  localparam int DXW = $clog2(MAX_DST_DIM);
  localparam int AW  = $clog2(MAX_SRC_WIDTH*MAX_SRC_HEIGHT);
  localparam int NXW = DXW + XW;
  localparam int NYW = DXW + YW;

  logic [8:0]  src_width_r, src_height_r;
  logic [12:0] dst_width_r, dst_height_r;
  logic [31:0] sw, sh, dw, dh, col, row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
      dst_width_r  <= DST_WIDTH_RST;
      dst_height_r <= DST_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data[8:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_data[8:0];
        CFG_DST_WIDTH:  dst_width_r  <= cfg_data;
        CFG_DST_HEIGHT: dst_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sw = 32'(src_width_r);
    if (sw < 32'd1) sw = 32'd1;
    if (sw > 32'(MAX_SRC_WIDTH)) sw = 32'(MAX_SRC_WIDTH);
    sh = 32'(src_height_r);
    if (sh < 32'd1) sh = 32'd1;
    if (sh > 32'(MAX_SRC_HEIGHT)) sh = 32'(MAX_SRC_HEIGHT);
    dw = 32'(dst_width_r);
    if (dw < 32'd2) dw = 32'd2;
    if (dw > 32'(MAX_DST_DIM)) dw = 32'(MAX_DST_DIM);
    dh = 32'(dst_height_r);
    if (dh < 32'd2) dh = 32'd2;
    if (dh > 32'(MAX_DST_DIM)) dh = 32'(MAX_DST_DIM);
    col = 32'(in_data.dst_col);
    if (col > dw - 32'd1) col = dw - 32'd1;
    row = 32'(in_data.dst_row);
    if (row > dh - 32'd1) row = dh - 32'd1;
  end

  assign is_prod = (in_data.func == FUNC_PRODUCE);
  assign wr_ok   = (32'(in_data.src_col) < 32'(MAX_SRC_WIDTH)) &&
                   (32'(in_data.src_row) < 32'(MAX_SRC_HEIGHT));
  assign waddr   = AW'(32'(in_data.src_row) * 32'(MAX_SRC_WIDTH) + 32'(in_data.src_col));
  assign pix     = '{red: in_data.in_red, green: in_data.in_green, blue: in_data.in_blue};
  assign swm1    = XW'(sw - 32'd1);
  assign shm1    = YW'(sh - 32'd1);
  assign dx      = DXW'(dw - 32'd1);
  assign dy      = DXW'(dh - 32'd1);
  assign nx      = NXW'(col[DXW-1:0]) * NXW'(swm1);
  assign ny      = NYW'(row[DXW-1:0]) * NYW'(shm1);

endmodule
`default_nettype wire

### rtl/bui_back.sv
// Back part: coordinate division, frame store access, weighting and final division.
`default_nettype none
module bui_back import bui_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_DIM    = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       valid_i,
  output logic                            pop,
  input  wire logic                       is_prod,
  input  wire logic                       wr_ok,
  input  wire logic [$clog2(MAX_SRC_WIDTH*MAX_SRC_HEIGHT)-1:0] waddr,
  input  wire pixel_t                     pix,
  input  wire logic [$clog2(MAX_DST_DIM)+$clog2(MAX_SRC_WIDTH)-1:0]  nx,
  input  wire logic [$clog2(MAX_DST_DIM)-1:0]  dx,
  input  wire logic [$clog2(MAX_DST_DIM)+$clog2(MAX_SRC_HEIGHT)-1:0] ny,
  input  wire logic [$clog2(MAX_DST_DIM)-1:0]  dy,
  input  wire logic [$clog2(MAX_SRC_WIDTH)-1:0]  swm1,
  input  wire logic [$clog2(MAX_SRC_HEIGHT)-1:0] shm1,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output out_item_t                       out_data,
  output back_status_t                    status
);

  localparam int XW  = $clog2(MAX_SRC_WIDTH);
  localparam int YW  = $clog2(MAX_SRC_HEIGHT);
  localparam int DXW = $clog2(MAX_DST_DIM);
  localparam int AW  = $clog2(MAX_SRC_WIDTH*MAX_SRC_HEIGHT);
  localparam int NXW = DXW + XW;
  localparam int NYW = DXW + YW;
  localparam int QW  = (XW > YW) ? XW : YW;
  localparam int QNW = DXW + QW;
  localparam int WW  = 2 * DXW;
  localparam int PW  = WW + 8;
  localparam int SW  = WW + 10;
  localparam int TXW = 2 + AW + 24 + XW;

  logic en;
  assign en  = !(out_valid && out_stall);
  assign pop = en && valid_i;

  logic                   xv, yv;
  logic [0:0][QNW-1:0]    x_num;
  logic [0:0][QNW-1:0]    y_num;
  logic [0:0][QW-1:0]     xq;
  logic [0:0][QW-1:0]     yq;
  logic [0:0][DXW-1:0]    xr, yr;
  logic [DXW-1:0]         xd, yd;
  logic [TXW-1:0]         xt;
  logic [YW-1:0]          yt;
  logic                   a_prod, a_wok;
  logic [AW-1:0]          a_waddr;
  pixel_t                 a_pix;
  logic [XW-1:0]          a_swm1;

  assign x_num[0] = QNW'(nx);
  assign y_num[0] = QNW'(ny);

  bui_div #(.LANES(1), .NW(QNW), .DW(DXW), .QB(QW), .TW(TXW)) u_div_x (
    .clk, .rst_n, .en, .valid_i,
    .num_i (x_num), .div_i (dx), .tag_i ({is_prod, wr_ok, waddr, pix, swm1}),
    .valid_o (xv), .quot_o (xq), .rem_o (xr), .div_o (xd), .tag_o (xt)
  );

  // The lower-neighbor limit rides the y divider so both axes stay aligned.
  bui_div #(.LANES(1), .NW(QNW), .DW(DXW), .QB(QW), .TW(YW)) u_div_y (
    .clk, .rst_n, .en, .valid_i,
    .num_i (y_num), .div_i (dy), .tag_i (shm1),
    .valid_o (yv), .quot_o (yq), .rem_o (yr), .div_o (yd), .tag_o (yt)
  );

  assign {a_prod, a_wok, a_waddr, a_pix, a_swm1} = xt;

  logic [XW-1:0]  x1, x2;
  logic [YW-1:0]  y1, y2;
  logic [AW-1:0]  raddr [4];
  logic [WW-1:0]  w_nxt [4];
  logic           ram_we;
  pixel_t         p [4];

  assign x1 = xq[0][XW-1:0];
  assign y1 = yq[0][YW-1:0];
  assign x2 = (x1 < a_swm1) ? x1 + XW'(1) : a_swm1;
  assign y2 = (y1 < yt) ? y1 + YW'(1) : yt;

  assign raddr[0] = AW'(32'(y1) * 32'(MAX_SRC_WIDTH) + 32'(x1));
  assign raddr[1] = AW'(32'(y2) * 32'(MAX_SRC_WIDTH) + 32'(x1));
  assign raddr[2] = AW'(32'(y1) * 32'(MAX_SRC_WIDTH) + 32'(x2));
  assign raddr[3] = AW'(32'(y2) * 32'(MAX_SRC_WIDTH) + 32'(x2));

  assign w_nxt[0] = WW'(xd - xr[0]) * WW'(yd - yr[0]);
  assign w_nxt[1] = WW'(xd - xr[0]) * WW'(yr[0]);
  assign w_nxt[2] = WW'(xr[0]) * WW'(yd - yr[0]);
  assign w_nxt[3] = WW'(xr[0]) * WW'(yr[0]);

  assign ram_we = en && xv && !a_prod && a_wok;

  for (genvar k = 0; k < 4; k++) begin : g_store
    bui_ram #(.WIDTH(24), .DEPTH(MAX_SRC_WIDTH*MAX_SRC_HEIGHT)) u_ram (
      .clk, .we (ram_we), .waddr (a_waddr), .wdata (a_pix),
      .re (en), .raddr (raddr[k]), .rdata (p[k])
    );
  end

  logic           va_r, vb_r, vc_r;
  logic           prod_a_r, prod_b_r, prod_c_r;
  logic [WW-1:0]  w_r [4];
  logic [WW-1:0]  den_a_r, den_b_r, den_c_r;
  logic [PW-1:0]  prd_r [3][4];
  logic [2:0][SW-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= xv && yv;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a_r <= a_prod;
      prod_b_r <= prod_a_r;
      prod_c_r <= prod_b_r;
      den_a_r  <= WW'(xd) * WW'(yd);
      den_b_r  <= den_a_r;
      den_c_r  <= den_b_r;
      for (int k = 0; k < 4; k++) begin
        w_r[k] <= w_nxt[k];
      end
      for (int ch = 0; ch < 3; ch++) begin
        for (int k = 0; k < 4; k++) begin
          prd_r[ch][k] <= PW'(pix_chan(p[k], ch)) * PW'(w_r[k]);
        end
        sum_r[ch] <= SW'(prd_r[ch][0]) + SW'(prd_r[ch][1]) +
                     SW'(prd_r[ch][2]) + SW'(prd_r[ch][3]);
      end
    end
  end

  logic               fv;
  logic [2:0][7:0]    fq;
  logic [2:0][WW-1:0] fr;
  logic [WW-1:0]      fd;
  logic [0:0]         ft;

  bui_div #(.LANES(3), .NW(SW), .DW(WW), .QB(8), .TW(1)) u_div_out (
    .clk, .rst_n, .en, .valid_i (vc_r),
    .num_i (sum_r), .div_i (den_c_r), .tag_i (prod_c_r),
    .valid_o (fv), .quot_o (fq), .rem_o (fr), .div_o (fd), .tag_o (ft)
  );

  assign out_valid = fv && ft[0];
  assign out_data  = '{out_blue: fq[0], out_green: fq[1], out_red: fq[2]};
  assign status.rem_ok = (fr[0] < fd) && (fr[1] < fd) && (fr[2] < fd);

endmodule
`default_nettype wire
